// ----- src/multi_level_time_hysteresis_top_assert.svh -----
// Assertion macros for the multi-level time hysteresis filter.
// Used by multi_level_time_hysteresis_top; expects clk and rst in scope.
`ifndef MULTI_LEVEL_TIME_HYSTERESIS_TOP_ASSERT_SVH
`define MULTI_LEVEL_TIME_HYSTERESIS_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define MLTH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlth assertion failed");
// Next-cycle implication, disabled during reset.
`define MLTH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlth assertion failed");
`else
`define MLTH_ASSERT_NOW(label, ante, cons)
`define MLTH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/mlth_pkg.sv -----
// Types and constants for the multi-level time hysteresis filter.
// No dependencies; imported by multi_level_time_hysteresis_top and its bench.
`default_nettype none

package mlth_pkg;

  localparam int TIME_BITS = 32;
  localparam int HOLD_BITS = 32;
  localparam int LEVEL_W   = 2;
  localparam int NLEVELS   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = HOLD_BITS;

  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LVL_OK    = 2'd0;
  localparam level_t LVL_WARN  = 2'd1;
  localparam level_t LVL_ERROR = 2'd2;
  localparam level_t LVL_STALE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE = 1'b0,
    REG_HOLD_TICKS    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_now;
    level_t               raw_level;
  } mlth_item_t;

  typedef struct packed {
    level_t stable_out;
    level_t raw_out;
  } mlth_result_t;

endpackage

`default_nettype wire

// ----- src/multi_level_time_hysteresis_top.sv -----
// Multi-level time hysteresis filter: top level with stamp state and output stage.
// Depends on mlth_pkg and multi_level_time_hysteresis_top_assert.svh.
// An accepted word is registered into result, or into skid while result is held.
// Throughput: one word per cycle while skid is empty; the result register plus
// a one-word skid register let item_stall come from a register, not from result_stall.
// Reset (rst, synchronous, active high): stable level STALE, all stamps
// invalid, filter disabled, hold_ticks zero, result and skid empty.
`default_nettype none
`include "multi_level_time_hysteresis_top_assert.svh"

module multi_level_time_hysteresis_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire mlth_pkg::mlth_item_t            item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output mlth_pkg::mlth_result_t               result,
  input  wire logic                            cfg_we,
  input  wire logic [mlth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mlth_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mlth_pkg::*;

  // Configuration registers.
  logic                 filter_enable;
  logic [HOLD_BITS-1:0] hold_ticks;

  // Filter state: stable level and first-seen stamps per level, both directions.
  level_t               stable_lvl;
  logic [NLEVELS-1:0]   rise_valid;
  logic [TIME_BITS-1:0] rise_time [NLEVELS];
  logic [NLEVELS-1:0]   fall_valid;
  logic [TIME_BITS-1:0] fall_time [NLEVELS];

  // Next-state values for one accepted word.
  level_t               stable_lvl_next;
  logic [NLEVELS-1:0]   rise_valid_next;
  logic [TIME_BITS-1:0] rise_time_next [NLEVELS];
  logic [NLEVELS-1:0]   fall_valid_next;
  logic [TIME_BITS-1:0] fall_time_next [NLEVELS];

  // Output stage: result register and one skid word behind it.
  logic         skid_valid;
  mlth_result_t skid;
  mlth_result_t result_next;

  logic accept;
  logic drain;

  // Stall only on a full skid word: that register decouples the two sides.
  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign drain      = result_valid && !result_stall;

  // ---------------------------------------------------------------------------
  // Filter step: stamp, then move. Four levels, all in parallel.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [NLEVELS-1:0]   rise_ok;
    logic [NLEVELS-1:0]   fall_ok;
    logic [TIME_BITS-1:0] rise_elapsed;
    logic [TIME_BITS-1:0] fall_elapsed;
    logic                 up_hit;
    logic                 down_hit;
    level_t               up_lvl;
    level_t               down_lvl;
    level_t               l_lvl;

    rise_valid_next = rise_valid;
    fall_valid_next = fall_valid;
    rise_time_next  = rise_time;
    fall_time_next  = fall_time;
    stable_lvl_next = stable_lvl;
    rise_ok         = '0;
    fall_ok         = '0;
    rise_elapsed    = '0;
    fall_elapsed    = '0;
    up_hit          = 1'b0;
    down_hit        = 1'b0;
    up_lvl          = stable_lvl;
    down_lvl        = stable_lvl;
    l_lvl           = LVL_OK;

    if (filter_enable) begin
      // Drop stamps the input no longer reaches; stamp newly reached levels.
      for (int l = 0; l < NLEVELS; l++) begin
        l_lvl = level_t'(l);
        if (l_lvl > item.raw_level) begin
          rise_valid_next[l] = 1'b0;
        end else if (l_lvl > stable_lvl && !rise_valid[l]) begin
          rise_valid_next[l] = 1'b1;
          rise_time_next[l]  = item.time_now;
        end
        if (l_lvl < item.raw_level) begin
          fall_valid_next[l] = 1'b0;
        end else if (l_lvl < stable_lvl && !fall_valid[l]) begin
          fall_valid_next[l] = 1'b1;
          fall_time_next[l]  = item.time_now;
        end
      end

      // Held long enough: modulo elapsed time against hold_ticks.
      for (int l = 0; l < NLEVELS; l++) begin
        rise_elapsed = item.time_now - rise_time_next[l];
        fall_elapsed = item.time_now - fall_time_next[l];
        rise_ok[l]   = rise_valid_next[l] && (rise_elapsed >= hold_ticks);
        fall_ok[l]   = fall_valid_next[l] && (fall_elapsed >= hold_ticks);
      end

      // Upward: highest qualifying level in (stable, raw].
      for (int l = 0; l < NLEVELS; l++) begin
        l_lvl = level_t'(l);
        if (l_lvl > stable_lvl && l_lvl <= item.raw_level && rise_ok[l]) begin
          up_hit = 1'b1;
          up_lvl = l_lvl;
        end
      end

      // Downward: lowest qualifying level in [raw, stable), scanned from the top.
      for (int l = NLEVELS - 1; l >= 0; l--) begin
        l_lvl = level_t'(l);
        if (l_lvl < stable_lvl && l_lvl >= item.raw_level && fall_ok[l]) begin
          down_hit = 1'b1;
          down_lvl = l_lvl;
        end
      end

      // A move clears every stamp of the opposite direction.
      if (up_hit) begin
        stable_lvl_next = up_lvl;
        fall_valid_next = '0;
      end else if (down_hit) begin
        stable_lvl_next = down_lvl;
        rise_valid_next = '0;
      end
    end else begin
      // Pass-through: follow the input, leave stamps as they are.
      stable_lvl_next = item.raw_level;
    end

    result_next.stable_out = stable_lvl_next;
    result_next.raw_out    = item.raw_level;
  end

  // ---------------------------------------------------------------------------
  // Configuration writes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      hold_ticks    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_HOLD_TICKS:    hold_ticks    <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Filter state: advance on every accepted word.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_lvl <= LVL_STALE;
      rise_valid <= '0;
      fall_valid <= '0;
    end else if (accept) begin
      stable_lvl <= stable_lvl_next;
      rise_valid <= rise_valid_next;
      fall_valid <= fall_valid_next;
    end
  end

  // Stamp values are gated by their valid bits and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      rise_time <= rise_time_next;
      fall_time <= fall_time_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: result register refills from skid first, else from the step.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (drain || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      // Result is held by the consumer: park the new word.
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain || !result_valid) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= result_next;
      end
    end else if (accept) begin
      skid <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Skid word only exists behind an occupied result register.
  `MLTH_ASSERT_NOW(a_skid_behind_result, skid_valid, result_valid)
  // Disabled filter: stable level takes the accepted raw level.
  `MLTH_ASSERT_NEXT(a_pass_through, accept && !filter_enable, stable_lvl == $past(item.raw_level))
  // Zero hold: stable level lands on the raw level at once.
  `MLTH_ASSERT_NEXT(a_zero_hold, accept && filter_enable && (hold_ticks == '0), stable_lvl == $past(item.raw_level))

endmodule

`default_nettype wire

// ----- dv/multi_level_time_hysteresis_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for multi_level_time_hysteresis_top: directed table, then random phases.
// Depends on mlth_pkg and top level; results are compared to an in-bench model or pinned levels.

module multi_level_time_hysteresis_top_tb;
  import mlth_pkg::*;

  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 235;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int REPORT_LIMIT    = 10;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  mlth_item_t            item;
  logic                  result_valid;
  logic                  result_stall;
  mlth_result_t          result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multi_level_time_hysteresis_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // One row of the directed table: either a register write or a word.
  // For a word, value is the timestamp; pinned marks a stable level typed in by hand.
  typedef struct packed {
    bit                    is_write;
    cfg_reg_t              which;
    logic [CFG_DATA_W-1:0] value;
    level_t                lvl;
    bit                    pinned;
    level_t                pin;
  } plan_row_t;

  typedef struct packed {
    bit     pinned;
    level_t lvl;
  } pin_t;

  plan_row_t    plan[$];
  pin_t         pins_due[$];     // hand-typed stable levels, one per word sent
  mlth_result_t results_due[$];  // filter outputs still to come out of the block

  // Filter model state: its own copy of registers, stable level and stamps.
  bit                   mdl_enable;
  logic [HOLD_BITS-1:0] mdl_hold;
  level_t               mdl_stable;
  bit   [NLEVELS-1:0]   up_armed;
  bit   [NLEVELS-1:0]   down_armed;
  logic [TIME_BITS-1:0] up_since   [NLEVELS];
  logic [TIME_BITS-1:0] down_since [NLEVELS];

  // Knobs shared between the stimulus and the receiver process.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_off_req = 0;

  int words_in     = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int mismatches   = 0;
  int input_held   = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset the model to the block's reset values.
  task automatic model_reset();
    mdl_enable = 1'b0;
    mdl_hold   = '0;
    mdl_stable = LVL_STALE;
    up_armed   = '0;
    down_armed = '0;
    for (int l = 0; l < NLEVELS; l++) begin
      up_since[l]   = '0;
      down_since[l] = '0;
    end
  endtask

  // A stamp counts once (now - since) mod 2^TIME_BITS has reached the hold.
  function automatic bit held_long(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] since);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = now - since;
    return elapsed >= mdl_hold;
  endfunction

  // Advance the filter by one word and return the new stable level.
  function automatic level_t filter_step(input logic [TIME_BITS-1:0] now, input level_t lvl);
    int l;
    if (!mdl_enable) begin
      // pass-through: stamps stay as they are
      mdl_stable = lvl;
      return mdl_stable;
    end
    // Stamp the first sighting of every level between stable and input;
    // drop stamps the input no longer reaches.
    for (l = 0; l < NLEVELS; l++) begin
      if (l > lvl) begin
        up_armed[l] = 1'b0;
      end else if (l > mdl_stable && !up_armed[l]) begin
        up_armed[l] = 1'b1;
        up_since[l] = now;
      end
      if (l < lvl) begin
        down_armed[l] = 1'b0;
      end else if (l < mdl_stable && !down_armed[l]) begin
        down_armed[l] = 1'b1;
        down_since[l] = now;
      end
    end
    // Rising: highest level that has lasted wins and kills the falling stamps.
    for (l = lvl; l > mdl_stable; l--) begin
      if (up_armed[l] && held_long(now, up_since[l])) begin
        mdl_stable = level_t'(l);
        down_armed = '0;
        return mdl_stable;
      end
    end
    // Falling: scan from the input level up toward the stable level.
    for (l = lvl; l < mdl_stable; l++) begin
      if (down_armed[l] && held_long(now, down_since[l])) begin
        mdl_stable = level_t'(l);
        up_armed   = '0;
        return mdl_stable;
      end
    end
    return mdl_stable;
  endfunction

  // Monitor: all handshakes are sampled here, at the edge where they complete.
  // Every driven signal changes by NBA, so these reads see pre-edge values.
  always @(posedge clk) begin : monitor
    mlth_result_t due;
    pin_t         pin;
    bit           moved;
    if (rst) begin
      model_reset();
      results_due.delete();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_index))
          REG_FILTER_ENABLE: mdl_enable = cfg_data[0];
          REG_HOLD_TICKS:    mdl_hold   = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_stall) input_held++;
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        words_in++;
        pin = (pins_due.size() != 0) ? pins_due.pop_front() : pin_t'(0);
        due.stable_out = filter_step(item.time_now, item.raw_level);
        due.raw_out    = item.raw_level;
        // a hand-typed level, where given, stands in for the model's
        if (pin.pinned) due.stable_out = pin.lvl;
        results_due.push_back(due);
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result: stable %0d raw %0d",
                     $realtime, result.stable_out, result.raw_out);
        end else begin
          due = results_due.pop_front();
          if (result.stable_out !== due.stable_out || result.raw_out !== due.raw_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("[%0t] result %0d mismatch: stable exp %0d got %0d, raw exp %0d got %0d",
                       $realtime, results_seen, due.stable_out, result.stable_out,
                       due.raw_out, result.raw_out);
          end
        end
      end
      // Watchdog: count cycles without any handshake.
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, results_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_off_left;
    hold_off_left = 0;
    result_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        result_stall <= 1'b1;
        hold_off_left--;
      end else if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Offer one word; return at the edge that accepts it, leaving valid high.
  task automatic push_word(input logic [TIME_BITS-1:0] stamp, input level_t lvl,
                           input bit pinned, input level_t pin);
    mlth_item_t w;
    w.time_now  = stamp;
    w.raw_level = lvl;
    pins_due.push_back(pin_t'({pinned, pin}));
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Write a register once the block has drained.
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    item_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  function automatic plan_row_t cfg_row(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] v);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.which    = which;
    r.value    = v;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic [TIME_BITS-1:0] t, input level_t lvl,
                                         input bit pinned, input level_t pin);
    plan_row_t r;
    r        = '0;
    r.value  = t;
    r.lvl    = lvl;
    r.pinned = pinned;
    r.pin    = pin;
    return r;
  endfunction

  initial begin : stimulus
    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  step;
    logic [CFG_DATA_W-1:0] hold;
    bit                    en;
    level_t                lvl;
    int                    pick;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FILTER_ENABLE;
    cfg_data   = '0;

    // Pass-through: stable follows every level, timestamps at both ends.
    plan.push_back(cfg_row(REG_FILTER_ENABLE, 0));
    plan.push_back(word_row(32'h0000_0000, LVL_OK,    1, LVL_OK));
    plan.push_back(word_row(32'hFFFF_FFFF, LVL_WARN,  1, LVL_WARN));
    plan.push_back(word_row(32'h0000_0001, LVL_ERROR, 1, LVL_ERROR));
    plan.push_back(word_row(32'h0000_0002, LVL_STALE, 1, LVL_STALE));
    // Largest hold: only an elapsed count of all ones qualifies, reached by a
    // timestamp one below the stamp (wraparound).
    plan.push_back(cfg_row(REG_HOLD_TICKS, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_FILTER_ENABLE, 1));
    plan.push_back(word_row(32'd100, LVL_OK, 1, LVL_STALE));
    plan.push_back(word_row(32'd99,  LVL_OK, 1, LVL_OK));
    // Zero hold: a new level moves the stable level on first sight.
    plan.push_back(cfg_row(REG_HOLD_TICKS, 0));
    plan.push_back(word_row(32'd5, LVL_STALE, 1, LVL_STALE));
    plan.push_back(word_row(32'd6, LVL_WARN,  1, LVL_WARN));
    // Hold of ten: one short, then exactly at the boundary.
    plan.push_back(cfg_row(REG_HOLD_TICKS, 10));
    plan.push_back(word_row(32'd1000, LVL_ERROR, 1, LVL_WARN));
    plan.push_back(word_row(32'd1009, LVL_ERROR, 1, LVL_WARN));
    plan.push_back(word_row(32'd1010, LVL_ERROR, 1, LVL_ERROR));
    plan.push_back(word_row(32'd1011, LVL_STALE, 0, LVL_OK));
    // Disabled filter leaves the STALE stamp alive; it fires after re-enable.
    plan.push_back(cfg_row(REG_FILTER_ENABLE, 0));
    plan.push_back(word_row(32'd1012, LVL_OK, 1, LVL_OK));
    plan.push_back(cfg_row(REG_FILTER_ENABLE, 1));
    plan.push_back(word_row(32'd1030, LVL_STALE, 0, LVL_OK));
    // Falling stamps, partial clear, then a move down.
    plan.push_back(word_row(32'd1031, LVL_OK,   0, LVL_OK));
    plan.push_back(word_row(32'd1035, LVL_WARN, 0, LVL_OK));
    plan.push_back(word_row(32'd1041, LVL_WARN, 0, LVL_OK));
    // Rise to the highest lasting level, then fall with stamps of mixed age.
    plan.push_back(word_row(32'd1100, LVL_STALE, 0, LVL_OK));
    plan.push_back(word_row(32'd1110, LVL_STALE, 0, LVL_OK));
    plan.push_back(word_row(32'd1111, LVL_OK,    0, LVL_OK));
    plan.push_back(word_row(32'd1115, LVL_ERROR, 0, LVL_OK));
    plan.push_back(word_row(32'd1121, LVL_WARN,  0, LVL_OK));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].which, plan[i].value);
      else push_word(plan[i].value, plan[i].lvl, plan[i].pinned, plan[i].pin);
    end

    // Random phases: each picks a setting and an idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      case (p)
        0: begin en = 1'b0; hold = $urandom_range(20);       end
        1: begin en = 1'b1; hold = '0;                       end
        2: begin en = 1'b1; hold = $urandom_range(1, 16);    end
        3: begin en = 1'b1; hold = '1;                       end
        4: begin en = 1'b1; hold = $urandom_range(20, 500);  end
        5: begin en = 1'b1; hold = 1;                        end
        6: begin en = 1'b0; hold = $urandom_range(2, 12);    end
        default: begin en = 1'b1; hold = $urandom;           end
      endcase
      write_reg(REG_HOLD_TICKS, hold);
      write_reg(REG_FILTER_ENABLE, en);
      now = $urandom;
      lvl = level_t'($urandom_range(3));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // hold the receiver off for a long stretch so the block backs up
        if (p == PRESSURE_PHASE && n == 40) hold_off_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 30)      step = $urandom_range(3);
        else if (pick < 60) step = hold + $urandom_range(2) - 1;
        else if (pick < 85) step = $urandom_range(40);
        else if (pick < 95) step = $urandom;
        else                step = '1;
        now  = now + step;
        // mostly runs of one level, so stamps get a chance to mature
        pick = $urandom_range(99);
        if (pick >= 65) lvl = level_t'($urandom_range(3));
        push_word(now, lvl, 0, LVL_OK);
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d words (%0d directed rows, %0d random phases, hold from 0 to all ones,",
             words_in, plan.size(), PHASES);
    $display("  filter on and off), %0d results checked, %0d register writes, input held %0d cycles",
             results_seen, reg_writes, input_held);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, results_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
